[rtl/core/bdq_pkg.sv]
// Package for the bounded deque with delete-by-value.
// Holds the depth, derived widths, command and status codes and the cell
// control struct. No dependencies.
package bdq_pkg;

  // Storage depth and derived widths
  localparam int unsigned Depth   = 16;
  localparam int unsigned DataW   = 32;
  localparam int unsigned CntW    = $clog2(Depth + 1);
  localparam int unsigned IdxW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CmdW    = 3;
  localparam int unsigned StatusW = 2;
  localparam int unsigned OccW    = 5;

  typedef enum logic [CmdW-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_DELETE     = 3'd4
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    ST_DONE     = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  // Broadcast control shared by every cell of the chain
  typedef struct packed {
    logic                    shift_r;    // push front: take left neighbor
    logic                    shift_l;    // pop front: take right neighbor
    logic                    load_back;  // push back: slot at count loads key
    logic                    del_scan;   // delete: shift left from first match on
    logic signed [DataW-1:0] key;        // push value or delete key
  } cell_ctrl_t;

endpackage

[rtl/core/bdq_cmd_if.sv]
// Command channel interface: valid/ready plus command and value.
// Depends on bdq_pkg for field widths.
interface bdq_cmd_if;
  logic                             valid;
  logic                             ready;
  logic [bdq_pkg::CmdW-1:0]         command;
  logic signed [bdq_pkg::DataW-1:0] value;

  modport source (output valid, command, value, input ready);
  modport sink   (input valid, command, value, output ready);
endinterface

[rtl/core/bdq_res_if.sv]
// Result channel interface: valid/ready plus status, occupancy, front and back.
// Depends on bdq_pkg for field widths.
interface bdq_res_if;
  logic                             valid;
  logic                             ready;
  logic [bdq_pkg::StatusW-1:0]      status;
  logic [bdq_pkg::OccW-1:0]         occupancy;
  logic signed [bdq_pkg::DataW-1:0] front_value;
  logic signed [bdq_pkg::DataW-1:0] back_value;

  modport source (output valid, status, occupancy, front_value, back_value, input ready);
  modport sink   (input valid, status, occupancy, front_value, back_value, output ready);
endinterface

[rtl/core/bdq_cell.sv]
// One storage cell of the deque chain: holds one entry, compares it to the
// key and moves data to or from its neighbors. Depends on bdq_pkg.
module bdq_cell (
  input  logic                             clk_i,
  input  bdq_pkg::cell_ctrl_t              ctrl_i,
  input  logic signed [bdq_pkg::DataW-1:0] left_val_i,
  input  logic signed [bdq_pkg::DataW-1:0] right_val_i,
  input  logic                             valid_i,
  input  logic                             is_back_i,
  input  logic                             seen_i,
  output logic                             seen_o,
  output logic                             match_o,
  output logic signed [bdq_pkg::DataW-1:0] val_o,
  output logic signed [bdq_pkg::DataW-1:0] val_d_o
);

  logic signed [bdq_pkg::DataW-1:0] val_q;
  logic signed [bdq_pkg::DataW-1:0] val_d;
  logic                             take_right;

  // Key compare and running "match at or before here" chain
  assign match_o = valid_i && (val_q == ctrl_i.key);
  assign seen_o  = seen_i || match_o;

  // Pop front shifts all cells; delete shifts from the removed slot on
  assign take_right = ctrl_i.shift_l || (ctrl_i.del_scan && seen_o);

  always_comb begin
    val_d = val_q;
    if (ctrl_i.shift_r) begin
      val_d = left_val_i;
    end else if (take_right) begin
      val_d = right_val_i;
    end else if (ctrl_i.load_back && is_back_i) begin
      val_d = ctrl_i.key;
    end
  end

  // Entry storage, no reset: only slots below the count are ever read
  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o   = val_q;
  assign val_d_o = val_d;

endmodule

[rtl/core/bounded_deque_with_delete.sv]
// Bounded double-ended queue with delete-by-value, built as a chain of cells.
// A result is registered and shown in the cycle after its command transfer.
// Throughput: one command per cycle while results drain; every cell compares and shifts in parallel.
// A waiting result holds off commands; one is taken in the cycle the result transfers.
// Reset: asynchronous active low; count and result valid clear, entries are not cleared.
// Depends on bdq_pkg, bdq_cmd_if, bdq_res_if and bdq_cell.
module bounded_deque_with_delete (
  input  logic   clk_i,
  input  logic   rst_ni,
  bdq_cmd_if.sink   cmd_i,
  bdq_res_if.source res_o
);

  localparam int unsigned Depth = bdq_pkg::Depth;
  localparam int unsigned CntW  = bdq_pkg::CntW;
  localparam int unsigned IdxW  = bdq_pkg::IdxW;
  localparam int unsigned DataW = bdq_pkg::DataW;

  logic [CntW-1:0]           cnt_q, cnt_d;
  logic                      out_valid_q;
  bdq_pkg::status_e          status_q, status_d;
  logic [bdq_pkg::OccW-1:0]  occ_q;
  logic signed [DataW-1:0]   front_q, front_d;
  logic signed [DataW-1:0]   back_q, back_d;

  logic                      accept;
  logic                      empty, full;
  bdq_pkg::cmd_e             cmd;
  bdq_pkg::cell_ctrl_t       ctrl;

  logic signed [DataW-1:0]   cell_val [Depth];
  logic signed [DataW-1:0]   cell_nxt [Depth];
  logic [Depth:0]            seen;
  logic [Depth-1:0]          hit, vld, bk;
  logic [IdxW-1:0]           tail_idx, new_tail_idx;
  logic                      head_hit, tail_hit, any_hit;

  // Handshake: take a command whenever the result register is free or draining
  assign cmd_i.ready = !out_valid_q || res_o.ready;
  assign accept      = cmd_i.valid && cmd_i.ready;
  assign cmd         = bdq_pkg::cmd_e'(cmd_i.command);

  assign empty = (cnt_q == '0);
  assign full  = (cnt_q == CntW'(Depth));

  // Per-slot occupancy and back-slot decode
  always_comb begin
    for (int i = 0; i < Depth; i++) begin
      vld[i] = (CntW'(i) < cnt_q);
      bk[i]  = (CntW'(i) == cnt_q);
    end
  end

  // Cell chain
  assign seen[0] = 1'b0;
  for (genvar g = 0; g < Depth; g++) begin : g_cell
    logic signed [DataW-1:0] left_val, right_val;
    if (g == 0) begin : g_first
      assign left_val = cmd_i.value;
    end else begin : g_mid
      assign left_val = cell_val[g-1];
    end
    if (g == Depth - 1) begin : g_last
      assign right_val = cell_val[g];
    end else begin : g_inner
      assign right_val = cell_val[g+1];
    end

    bdq_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .left_val_i (left_val),
      .right_val_i(right_val),
      .valid_i    (vld[g]),
      .is_back_i  (bk[g]),
      .seen_i     (seen[g]),
      .seen_o     (seen[g+1]),
      .match_o    (hit[g]),
      .val_o      (cell_val[g]),
      .val_d_o    (cell_nxt[g])
    );
  end

  // Head, tail and any-match flags for delete
  assign tail_idx = IdxW'(cnt_q - CntW'(1));
  assign head_hit = hit[0];
  assign tail_hit = hit[tail_idx];
  assign any_hit  = seen[Depth];

  // Command decode: cell control, count update and status
  always_comb begin
    ctrl          = '0;
    ctrl.key      = cmd_i.value;
    cnt_d         = cnt_q;
    status_d      = bdq_pkg::ST_DONE;
    case (cmd)
      bdq_pkg::CMD_PUSH_FRONT: begin
        if (full) begin
          status_d = bdq_pkg::ST_FULL;
        end else begin
          ctrl.shift_r = accept;
          cnt_d        = cnt_q + CntW'(1);
        end
      end
      bdq_pkg::CMD_PUSH_BACK: begin
        if (full) begin
          status_d = bdq_pkg::ST_FULL;
        end else begin
          ctrl.load_back = accept;
          cnt_d          = cnt_q + CntW'(1);
        end
      end
      bdq_pkg::CMD_POP_FRONT: begin
        if (empty) begin
          status_d = bdq_pkg::ST_EMPTY;
        end else begin
          ctrl.shift_l = accept;
          cnt_d        = cnt_q - CntW'(1);
        end
      end
      bdq_pkg::CMD_POP_BACK: begin
        if (empty) begin
          status_d = bdq_pkg::ST_EMPTY;
        end else begin
          cnt_d = cnt_q - CntW'(1);
        end
      end
      bdq_pkg::CMD_DELETE: begin
        if (empty) begin
          status_d = bdq_pkg::ST_EMPTY;
        end else if (!any_hit) begin
          status_d = bdq_pkg::ST_NOTFOUND;
        end else begin
          // tail match without head match just drops the back entry
          ctrl.del_scan = accept && (head_hit || !tail_hit);
          cnt_d         = cnt_q - CntW'(1);
        end
      end
      default: begin
        status_d = bdq_pkg::ST_DONE;
      end
    endcase
  end

  // Front and back after the update, zero when empty
  assign new_tail_idx = IdxW'(cnt_d - CntW'(1));
  assign front_d = (cnt_d == '0) ? '0 : cell_nxt[0];
  assign back_d  = (cnt_d == '0) ? '0 : cell_nxt[new_tail_idx];

  // Count and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        cnt_q <= cnt_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      occ_q    <= bdq_pkg::OccW'(cnt_d);
      front_q  <= front_d;
      back_q   <= back_d;
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.status      = status_q;
  assign res_o.occupancy   = occ_q;
  assign res_o.front_value = front_q;
  assign res_o.back_value  = back_q;

  // Count never exceeds the storage depth
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("deque count above depth");

  // A push that fits grows the count by one
  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !full && (cmd == bdq_pkg::CMD_PUSH_FRONT || cmd == bdq_pkg::CMD_PUSH_BACK))
    |=> (cnt_q == $past(cnt_q) + CntW'(1)))
    else $error("push did not grow count");

  // Reported occupancy tracks the count register
  a_occ_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (occ_q == bdq_pkg::OccW'(cnt_q)))
    else $error("occupancy out of step with count");

endmodule
